>>> rtl/rws_pkg.sv
`timescale 1ns / 1ps

package rws_pkg;

    localparam int POP_DEPTH = 64;
    localparam int IDX_W     = $clog2(POP_DEPTH);
    localparam int CNT_W     = $clog2(POP_DEPTH + 1);

    localparam int FIT_W     = 24;
    localparam int FRAC_W    = 16;
    localparam int TOT_W     = 32;
    localparam int THR_W     = 32;
    localparam int PROD_W    = TOT_W + FRAC_W;
    localparam int POP_W     = 7;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int OUT_IDX_W = 6;

    // Running sum of up to POP_DEPTH scores never needs saturation.
    localparam int ACC_W     = FIT_W + CNT_W;
    localparam int CMP_W     = (ACC_W > THR_W) ? ACC_W : THR_W;
    localparam int SPAN_W    = (CNT_W > POP_W) ? CNT_W : POP_W;

    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam logic REG_POP_COUNT = 1'b0;

    localparam logic [TOT_W-1:0] ONE_Q16 = 32'h0001_0000;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SELECT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WHEEL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FALLBACK = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOPOP    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic accept;
        logic mul;
        logic scan;
        logic push;
    } rws_cmd_t;

    typedef struct packed {
        logic scan_needed;
        logic has_result;
        logic scan_done;
        logic out_free;
    } rws_sts_t;

endpackage

>>> rtl/rws_ctrl.sv
`timescale 1ns / 1ps

module rws_ctrl
    import rws_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rws_sts_t sts,
    output rws_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (sts.scan_needed)
                    begin
                        state_next = S_MUL;
                    end
                    else if (sts.has_result)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // The result waits here until the output register can take it.
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/rws_datapath.sv
`timescale 1ns / 1ps

module rws_datapath
    import rws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rws_cmd_t             cmd,
    output rws_sts_t             sts,
    input  logic [FUNC_W-1:0]    func,
    input  logic [FIT_W-1:0]     fitness,
    input  logic [FRAC_W-1:0]    random_fraction,
    input  logic [OUT_IDX_W-1:0] fallback_index,
    input  logic [POP_W-1:0]     population_count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [OUT_IDX_W-1:0] chosen_index
);

    logic [FIT_W-1:0]     score_mem [POP_DEPTH];

    logic [CNT_W-1:0]     loaded_count_reg, loaded_count_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [FRAC_W-1:0]    frac_reg;
    logic [CNT_W-1:0]     span_reg;
    logic [THR_W-1:0]     thr_reg;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [FIT_W-1:0]     rdata_reg;
    logic                 chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]     chk_idx_reg;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [STATUS_W-1:0]  pend_status_reg, pend_status_next;
    logic [OUT_IDX_W-1:0] pend_index_reg, pend_index_next;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [OUT_IDX_W-1:0] chosen_index_reg;

    logic                 is_load, is_select;
    logic                 store_full, mem_wr;
    logic [TOT_W:0]       total_sum;
    logic [SPAN_W-1:0]    pop_ext, loaded_ext, span_min;
    logic [TOT_W-1:0]     total_eff;
    logic [PROD_W-1:0]    product;
    logic                 issue, hit, last;

    assign is_load    = (func == FUNC_LOAD);
    assign is_select  = (func == FUNC_SELECT);
    assign store_full = (loaded_count_reg == CNT_W'(POP_DEPTH));
    assign mem_wr     = cmd.accept && is_load && !store_full;
    assign total_sum  = {1'b0, total_reg} + (TOT_W + 1)'(fitness);

    assign pop_ext    = SPAN_W'(population_count);
    assign loaded_ext = SPAN_W'(loaded_count_reg);
    assign span_min   = (pop_ext < loaded_ext) ? pop_ext : loaded_ext;

    assign total_eff  = (total_reg < ONE_Q16) ? ONE_Q16 : total_reg;
    assign product    = PROD_W'(total_eff) * PROD_W'(frac_reg);

    // Reads go out one per cycle; the compare stage checks each read in the cycle after it is issued.
    assign issue      = cmd.scan && (rd_idx_reg < span_reg);
    assign acc_next   = acc_reg + ACC_W'(rdata_reg);
    assign hit        = chk_valid_reg && (CMP_W'(acc_next) >= CMP_W'(thr_reg));
    assign last       = chk_valid_reg && (CNT_W'(chk_idx_reg) == span_reg - CNT_W'(1));

    assign sts.scan_needed = is_select && (population_count != '0) && (loaded_count_reg != '0);
    assign sts.has_result  = (func != FUNC_NONE);
    assign sts.scan_done   = hit || last;
    assign sts.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        loaded_count_next = loaded_count_reg;
        total_next        = total_reg;
        pend_status_next  = pend_status_reg;
        pend_index_next   = pend_index_reg;
        rd_idx_next       = rd_idx_reg;
        chk_valid_next    = chk_valid_reg;
        if (cmd.accept)
        begin
            pend_index_next = '0;
            case (func)
                FUNC_LOAD:
                begin
                    if (store_full)
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        pend_status_next  = ST_LOADED;
                        loaded_count_next = loaded_count_reg + CNT_W'(1);
                        total_next        = total_sum[TOT_W] ? '1 : total_sum[TOT_W-1:0];
                    end
                end
                FUNC_SELECT:
                begin
                    // Fallback stands unless the wheel finds a pick.
                    if (population_count == '0)
                    begin
                        pend_status_next = ST_NOPOP;
                    end
                    else
                    begin
                        pend_status_next = ST_FALLBACK;
                        pend_index_next  = fallback_index;
                    end
                end
                FUNC_CLEAR:
                begin
                    pend_status_next  = ST_CLEARED;
                    loaded_count_next = '0;
                    total_next        = '0;
                end
                default:
                begin
                    pend_status_next = pend_status_reg;
                end
            endcase
        end
        if (cmd.mul)
        begin
            rd_idx_next    = '0;
            chk_valid_next = 1'b0;
        end
        if (cmd.scan)
        begin
            chk_valid_next = issue;
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (hit)
            begin
                pend_status_next = ST_WHEEL;
                pend_index_next  = OUT_IDX_W'(chk_idx_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            score_mem[loaded_count_reg[IDX_W-1:0]] <= fitness;
        end
        rdata_reg <= score_mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg     <= rd_idx_reg[IDX_W-1:0];
        pend_status_reg <= pend_status_next;
        pend_index_reg  <= pend_index_next;
        if (cmd.accept)
        begin
            frac_reg <= random_fraction;
            span_reg <= CNT_W'(span_min);
        end
        if (cmd.mul)
        begin
            thr_reg <= product[PROD_W-1:FRAC_W];
            acc_reg <= '0;
        end
        else if (cmd.scan && chk_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.push)
        begin
            status_reg       <= pend_status_reg;
            chosen_index_reg <= pend_index_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_count_reg <= '0;
            total_reg        <= '0;
            rd_idx_reg       <= '0;
            chk_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            loaded_count_reg <= loaded_count_next;
            total_reg        <= total_next;
            rd_idx_reg       <= rd_idx_next;
            chk_valid_reg    <= chk_valid_next;
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_index = chosen_index_reg;

endmodule

>>> rtl/roulette_wheel_selector.sv
`timescale 1ns / 1ps

// Roulette-wheel selector. A load appends one Q8.16 score to a 64-entry store and adds it to
// a saturating 32-bit total; a clear empties the store; a select forms the threshold
// max(total, 1.0) * fraction and scans the stored scores in order for the first prefix sum
// that reaches it, returning the fallback index when no score decides and index 0 when
// population_count is zero; a load into a full store is refused with status FULL. A select
// forms the threshold in a multiply step, then walks the score store through its single read
// port one entry a cycle. The output register holds a finished result while the next item is
// taken; population_count is written through the APB port at any address with paddr[2] low.
module roulette_wheel_selector
    import rws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic [FIT_W-1:0]     fitness,
    input  logic [FRAC_W-1:0]    random_fraction,
    input  logic [OUT_IDX_W-1:0] fallback_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [OUT_IDX_W-1:0] chosen_index
);

    logic [POP_W-1:0] population_count_reg;
    logic             reg_sel;
    rws_cmd_t         cmd;
    rws_sts_t         sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1] == REG_POP_COUNT);
    assign prdata  = reg_sel ? APB_DW'(population_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            population_count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            population_count_reg <= pwdata[POP_W-1:0];
        end
    end

    rws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rws_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .func             (func),
        .fitness          (fitness),
        .random_fraction  (random_fraction),
        .fallback_index   (fallback_index),
        .population_count (population_count_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .chosen_index     (chosen_index)
    );

    // A new result must never overwrite one that has not been transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid || out_ready))
        else $error("result pushed over a pending output");

    // No item is taken while a select is still computing.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.scan || cmd.mul))
        else $error("input ready during select processing");

    // A wheel pick always lies inside the population.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (status != ST_WHEEL || chosen_index < population_count_reg))
        else $error("wheel pick outside population");

endmodule

>>> tb/rws_checker.sv
`timescale 1ns / 1ps

module rws_checker
    import rws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic [FIT_W-1:0]     fitness,
    input  logic [FRAC_W-1:0]    random_fraction,
    input  logic [OUT_IDX_W-1:0] fallback_index,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [STATUS_W-1:0]  status,
    input  logic [OUT_IDX_W-1:0] chosen_index,
    output int                   pending,
    output int                   errors
);

    localparam logic [APB_AW-1:0] POP_COUNT_ADDR = APB_AW'(4 * REG_POP_COUNT);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_IDX_W-1:0] index;
    } pick_t;

    logic [FIT_W-1:0] scores [POP_DEPTH];
    logic [CNT_W-1:0] n_loaded;
    logic [TOT_W-1:0] fitness_sum;
    logic [POP_W-1:0] population;
    pick_t            awaited_picks [$];
    int               err_n;

    initial begin
        pending = 0;
        errors  = 0;
        err_n   = 0;
    end

    // The running sum is kept wide enough that it never wraps.
    function automatic pick_t spin_wheel(input logic [FRAC_W-1:0] fraction,
                                         input logic [OUT_IDX_W-1:0] fallback);
        logic [TOT_W-1:0]  weight;
        logic [PROD_W-1:0] threshold;
        logic [PROD_W-1:0] acc;
        int                span;
        int                i;
        pick_t             res;
        res.status = ST_FALLBACK;
        res.index  = fallback;
        if (population == '0) begin
            res.status = ST_NOPOP;
            res.index  = '0;
            return res;
        end
        if (n_loaded == '0)
            return res;
        weight    = (fitness_sum < ONE_Q16) ? ONE_Q16 : fitness_sum;
        threshold = (PROD_W'(weight) * PROD_W'(fraction)) >> FRAC_W;
        span = int'(population);
        if (span > int'(n_loaded))
            span = int'(n_loaded);
        if (span > POP_DEPTH)
            span = POP_DEPTH;
        acc = '0;
        for (i = 0; i < span; i++)
        begin
            acc = acc + PROD_W'(scores[i]);
            if (acc >= threshold) begin
                res.status = ST_WHEEL;
                res.index  = OUT_IDX_W'(i);
                return res;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        pick_t           res;
        pick_t           want;
        logic [TOT_W:0]  wide_sum;
        if (!rst_n) begin
            n_loaded    = '0;
            fitness_sum = '0;
            population  = '0;
            awaited_picks.delete();
            pending <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == POP_COUNT_ADDR)
                population = pwdata[POP_W-1:0];

            if (in_valid && in_ready) begin
                case (func)
                    FUNC_LOAD:
                    begin
                        if (n_loaded >= POP_DEPTH) begin
                            res.status = ST_FULL;
                        end
                        else begin
                            scores[n_loaded] = fitness;
                            n_loaded         = n_loaded + 1'b1;
                            wide_sum         = {1'b0, fitness_sum} + (TOT_W + 1)'(fitness);
                            fitness_sum      = wide_sum[TOT_W] ? '1 : wide_sum[TOT_W-1:0];
                            res.status       = ST_LOADED;
                        end
                        res.index = '0;
                        awaited_picks.push_back(res);
                    end
                    FUNC_SELECT:
                    begin
                        awaited_picks.push_back(spin_wheel(random_fraction, fallback_index));
                    end
                    FUNC_CLEAR:
                    begin
                        n_loaded    = '0;
                        fitness_sum = '0;
                        res.status  = ST_CLEARED;
                        res.index   = '0;
                        awaited_picks.push_back(res);
                    end
                    FUNC_NONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid && out_ready) begin
                if (awaited_picks.size() == 0) begin
                    $error("unexpected transfer: status %0d chosen_index %0d",
                           status, chosen_index);
                    err_n++;
                end
                else begin
                    want = awaited_picks.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        err_n++;
                    end
                    if (chosen_index !== want.index) begin
                        $error("chosen_index: expected %0d, actual %0d",
                               want.index, chosen_index);
                        err_n++;
                    end
                end
            end
            pending <= awaited_picks.size();
        end
        errors <= err_n;
    end

endmodule

>>> tb/tb_roulette_wheel_selector.sv
`timescale 1ns / 1ps

module tb_roulette_wheel_selector;
    import rws_pkg::*;

    localparam int ITEM_TARGET   = 1700;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [APB_AW-1:0] POP_COUNT_ADDR = APB_AW'(4 * REG_POP_COUNT);

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func;
    logic [FIT_W-1:0]     fitness;
    logic [FRAC_W-1:0]    random_fraction;
    logic [OUT_IDX_W-1:0] fallback_index;
    logic                 out_valid;
    logic                 out_ready;
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] chosen_index;

    int pending;
    int mismatches;
    int cycle_count;
    int n_loads;
    int n_selects;
    int n_clears;
    int n_ignored;
    int n_pop_writes;
    bit steady;

    roulette_wheel_selector u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .fitness         (fitness),
        .random_fraction (random_fraction),
        .fallback_index  (fallback_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .chosen_index    (chosen_index)
    );

    rws_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .fitness         (fitness),
        .random_fraction (random_fraction),
        .fallback_index  (fallback_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .chosen_index    (chosen_index),
        .pending         (pending),
        .errors          (mismatches)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none at all in steady phases.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [FIT_W-1:0] draw_score();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return '1;
            2: return FIT_W'($urandom_range(1, 255));
            3: return FIT_W'($urandom_range(0, 65535));
            default: return FIT_W'($urandom);
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] draw_fraction();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return FRAC_W'($urandom);
    endfunction

    function automatic logic [POP_W-1:0] draw_population();
        int r;
        r = $urandom_range(0, 7);
        case (r)
            0: return '0;
            1: return POP_W'(1);
            2: return POP_W'(POP_DEPTH);
            3: return '1;
            default: return POP_W'($urandom_range(2, POP_DEPTH - 1));
        endcase
    endfunction

    // Receiver side: bursts of ready with stalls in between.
    initial
    begin
        int burst;
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            burst = steady ? 1 : $urandom_range(1, 8);
            out_ready <= 1'b1;
            repeat (burst) @(posedge clk);
            stall = idle_span();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic push_item(input logic [FUNC_W-1:0]    f,
                             input logic [FIT_W-1:0]     fit,
                             input logic [FRAC_W-1:0]    frac,
                             input logic [OUT_IDX_W-1:0] fb);
        int gap;
        gap = idle_span();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        func            <= f;
        fitness         <= fit;
        random_fraction <= frac;
        fallback_index  <= fb;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        case (f)
            FUNC_LOAD:   n_loads++;
            FUNC_SELECT: n_selects++;
            FUNC_CLEAR:  n_clears++;
            default:     n_ignored++;
        endcase
    endtask

    task automatic push_load(input logic [FIT_W-1:0] fit);
        push_item(FUNC_LOAD, fit, FRAC_W'($urandom), OUT_IDX_W'($urandom));
    endtask

    task automatic push_select(input logic [FRAC_W-1:0] frac, input logic [OUT_IDX_W-1:0] fb);
        push_item(FUNC_SELECT, FIT_W'($urandom), frac, fb);
    endtask

    task automatic push_clear();
        push_item(FUNC_CLEAR, FIT_W'($urandom), FRAC_W'($urandom), OUT_IDX_W'($urandom));
    endtask

    // Drop valid, wait for every result, then give an ignored item time to drain.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_population(input logic [POP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POP_COUNT_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_pop_writes++;
    endtask

    task automatic random_mix_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38)
            push_load(draw_score());
        else if (r < 88)
            push_select(draw_fraction(), OUT_IDX_W'($urandom));
        else if (r < 94)
            push_clear();
        else
            push_item(FUNC_NONE, FIT_W'($urandom), FRAC_W'($urandom), OUT_IDX_W'($urandom));
    endtask

    initial
    begin
        int n;
        int k;
        int style;
        int i;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_valid        <= 1'b0;
        func            <= FUNC_LOAD;
        fitness         <= '0;
        random_fraction <= '0;
        fallback_index  <= '0;
        steady          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: population still zero after reset.
        push_select('1, OUT_IDX_W'(21));
        push_load('1);
        push_clear();
        settle();
        write_population(POP_W'(POP_DEPTH));
        push_select(FRAC_W'(16'h1234), '1);
        push_load('0);
        push_load(FIT_W'(24'h000100));
        push_select('0, OUT_IDX_W'(5));
        // Total below 1.0, so the wheel cannot reach the threshold.
        push_select('1, OUT_IDX_W'(42));
        push_item(FUNC_NONE, '1, '1, '1);
        push_load('1);
        push_load(FIT_W'(1));
        push_select('1, OUT_IDX_W'(7));
        push_select(FRAC_W'(16'h8000), OUT_IDX_W'(7));
        push_select(FRAC_W'(1), OUT_IDX_W'(7));
        settle();
        // Scan cut short by a population smaller than the loaded count.
        write_population(POP_W'(1));
        push_select('1, '1);
        push_select('0, '1);
        settle();
        write_population('1);
        push_select('1, OUT_IDX_W'(9));
        push_clear();
        push_select(FRAC_W'(16'h4000), OUT_IDX_W'(33));
        push_load(FIT_W'(24'h010000));
        push_select('1, OUT_IDX_W'(33));
        push_select('0, OUT_IDX_W'(33));

        // Random phases, each under its own population setting.
        while (n_loads + n_selects + n_clears < ITEM_TARGET) begin
            settle();
            write_population(draw_population());
            steady = ($urandom_range(0, 3) == 0);
            n      = $urandom_range(40, 120);
            style  = $urandom_range(0, 3);
            if (style <= 1) begin
                // Well-formed: clear, fill the wheel, then spin it.
                push_clear();
                k = ($urandom_range(0, 5) == 0) ? $urandom_range(POP_DEPTH - 2, POP_DEPTH + 6)
                                                : $urandom_range(1, 40);
                for (i = 0; i < k; i++)
                    push_load(draw_score());
                for (i = 0; i < n - k; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        random_mix_item();
                    else
                        push_select(draw_fraction(), OUT_IDX_W'($urandom));
                end
            end
            else if (style == 2) begin
                for (i = 0; i < n; i++)
                    random_mix_item();
            end
            else begin
                // Loads and selects interleaved with no clear, running into a full store.
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 1) == 0)
                        push_load(draw_score());
                    else
                        push_select(draw_fraction(), OUT_IDX_W'($urandom));
                end
            end
        end
        steady = 1'b0;
        settle();

        $display("covered %0d loads, %0d selects, %0d clears and %0d ignored items",
                 n_loads, n_selects, n_clears, n_ignored);
        $display("over %0d population_count writes in %0d cycles", n_pop_writes, cycle_count);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
